// File: sv/ishs_pkg.sv
// ----------------------------------------------------------------------------
// ishs_pkg
// Types and fixed widths shared by the indented slab harmonic score unit.
// ----------------------------------------------------------------------------
package ishs_pkg;

    localparam int COORD_W   = 32;  // coordinate width, signed
    localparam int RAD_W     = 62;  // square root radicand width
    localparam int ROOT_BITS = 31;  // square root result width
    localparam int TGT_W     = 34;  // target height width, signed
    localparam int D_W       = 35;  // z minus target, signed
    localparam int UD_W      = 34;  // magnitude of z minus target
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE  = 3'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } cmd_t;

    typedef struct packed {
        logic [47:0]        score;
        logic signed [47:0] deriv_z;
        logic               in_dome;
    } result_t;

    // side data carried alongside the square root pipeline
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [TGT_W-1:0]   base;
        logic                      dome;
    } side_t;

endpackage

// File: sv/ishs_sqrt.sv
// ----------------------------------------------------------------------------
// ishs_sqrt
// Pipelined integer square root, one result bit per stage, rounded down.
// ----------------------------------------------------------------------------
module ishs_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [ishs_pkg::RAD_W-1:0]    in_rad,
    input  ishs_pkg::side_t               in_side,
    output logic                          out_valid,
    output logic [ishs_pkg::ROOT_BITS-1:0] out_root,
    output ishs_pkg::side_t               out_side
);

    localparam int NS = ishs_pkg::ROOT_BITS;
    localparam int W  = ishs_pkg::RAD_W;

    logic [W-1:0]          n_reg   [NS];
    logic [W-1:0]          res_reg [NS];
    logic                  v_reg   [NS];
    ishs_pkg::side_t       side_reg [NS];

    for (genvar i = 0; i < NS; i++) begin : g_stage
        localparam logic [W-1:0] BIT = W'(1) << (2 * (NS - 1 - i));
        logic [W-1:0]    n_prev;
        logic [W-1:0]    res_prev;
        logic            v_prev;
        ishs_pkg::side_t side_prev;
        logic [W-1:0]    trial;

        if (i == 0) begin : g_first
            assign n_prev    = in_rad;
            assign res_prev  = '0;
            assign v_prev    = in_valid;
            assign side_prev = in_side;
        end
        else begin : g_next
            assign n_prev    = n_reg[i-1];
            assign res_prev  = res_reg[i-1];
            assign v_prev    = v_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        assign trial = res_prev + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[i] <= side_prev;
            if (n_prev >= trial)
            begin
                n_reg[i]   <= n_prev - trial;
                res_reg[i] <= (res_prev >> 1) + BIT;
            end
            else
            begin
                n_reg[i]   <= n_prev;
                res_reg[i] <= res_prev >> 1;
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_root  = res_reg[NS-1][NS-1:0];
    assign out_side  = side_reg[NS-1];

`ifndef SYNTH
    a_sqrt_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, NS))
        else $error("sqrt word without matching input");
`endif

endmodule

// File: sv/indented_slab_harmonic_score_unit.sv
// ----------------------------------------------------------------------------
// indented_slab_harmonic_score_unit
// Harmonic score and z derivative of a particle above a slab with a
// spherical dome indent.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word on cmd is taken at each clock edge with start
//   high and busy low. busy stays low, so one word can enter every cycle.
//   Result channel: done is high for one cycle with the word on result;
//   results leave in input order and cannot be held off.
//   Configuration: cfg_index/cfg_data are written when cfg_valid is high;
//   cfg_ready is always high. Indexes past the register list are dropped.
//   Write registers only while no command is in flight.
// Timing:
//   done rises when the word has passed stages 0 to 2, the 31-stage
//   square root pipeline, and the offset, magnitude, product and result
//   registers. Throughput is one word per cycle.
// Reset:
//   rst_n clears all pipeline valid bits and loads radius 1.0, depth 0,
//   spring 1.0 and plane height 0.
// ----------------------------------------------------------------------------
module indented_slab_harmonic_score_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  ishs_pkg::cmd_t                  cmd,
    output logic                            done,
    output ishs_pkg::result_t               result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ishs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data
);

    localparam int CW   = ishs_pkg::COORD_W;
    localparam int UDW  = ishs_pkg::UD_W;
    localparam int P1W  = UDW + 31;
    localparam int SQW  = 2 * UDW;
    localparam int FULW = SQW + 31 + 1;

    // configuration
    logic [30:0]        radius_reg;
    logic [30:0]        depth_reg;
    logic [30:0]        spring_reg;
    logic signed [31:0] plane_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 31'd65536;
            depth_reg  <= 31'd0;
            spring_reg <= 31'd65536;
            plane_reg  <= 32'sd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ishs_pkg::CFG_RADIUS: radius_reg <= cfg_data[30:0];
                ishs_pkg::CFG_DEPTH:  depth_reg  <= cfg_data[30:0];
                ishs_pkg::CFG_SPRING: spring_reg <= cfg_data[30:0];
                ishs_pkg::CFG_PLANE:  plane_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // values derived from configuration, refreshed every cycle
    logic [63:0]                        a2_reg;
    logic [ishs_pkg::RAD_W-1:0]         rr_reg;
    logic                               fits_reg;
    logic signed [ishs_pkg::TGT_W-1:0]  base_reg;
    logic [31:0]                        two_r;

    assign two_r = {radius_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        fits_reg <= {1'b0, depth_reg} <= two_r;
        a2_reg   <= {33'd0, depth_reg} * ({32'd0, two_r} - {33'd0, depth_reg});
        rr_reg   <= {31'd0, radius_reg} * {31'd0, radius_reg};
        base_reg <= $signed({3'b0, depth_reg}) - $signed({3'b0, radius_reg});
    end

    // stage 0: magnitudes of x and y
    logic                 v0_reg;
    logic [CW-1:0]        ax_reg;
    logic [CW-1:0]        ay_reg;
    logic signed [CW-1:0] z0_reg;

    // stage 1: squares
    logic                 v1_reg;
    logic [2*CW-1:0]      xx_reg;
    logic [2*CW-1:0]      yy_reg;
    logic signed [CW-1:0] z1_reg;

    // stage 2: dome test and radicand
    logic                       v2_reg;
    logic [ishs_pkg::RAD_W-1:0] rad_reg;
    ishs_pkg::side_t            side2_reg;
    logic [2*CW:0]              r2;
    logic                       dome2;

    assign r2    = {1'b0, xx_reg} + {1'b0, yy_reg};
    assign dome2 = fits_reg && (r2 < {1'b0, a2_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg <= cmd.pos_x[CW-1] ? CW'(~cmd.pos_x + 1'b1) : cmd.pos_x;
        ay_reg <= cmd.pos_y[CW-1] ? CW'(~cmd.pos_y + 1'b1) : cmd.pos_y;
        z0_reg <= cmd.pos_z;
        xx_reg <= ax_reg * ax_reg;
        yy_reg <= ay_reg * ay_reg;
        z1_reg <= z0_reg;
        rad_reg         <= rr_reg - r2[ishs_pkg::RAD_W-1:0];
        side2_reg.z     <= z1_reg;
        side2_reg.base  <= base_reg;
        side2_reg.dome  <= dome2;
    end

    logic                           vs;
    logic [ishs_pkg::ROOT_BITS-1:0] root;
    ishs_pkg::side_t                side_s;

    ishs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_rad    (rad_reg),
        .in_side   (side2_reg),
        .out_valid (vs),
        .out_root  (root),
        .out_side  (side_s)
    );

    // target and offset
    logic signed [ishs_pkg::TGT_W-1:0] tgt;
    logic signed [ishs_pkg::D_W-1:0]   d_next;
    logic signed [ishs_pkg::D_W-1:0]   d_reg;
    logic                              vt_reg;
    logic                              dome_t_reg;

    assign tgt = side_s.dome ? side_s.base + $signed({3'b0, root})
                             : ishs_pkg::TGT_W'(plane_reg);
    assign d_next = ishs_pkg::D_W'(side_s.z) - ishs_pkg::D_W'(tgt);

    // magnitude
    logic [UDW-1:0] ud_reg;
    logic           pos_a_reg;
    logic           dome_a_reg;
    logic           va_reg;

    // products
    logic [P1W-1:0] p1_reg;
    logic [SQW-1:0] sq_reg;
    logic           pos_m1_reg;
    logic           dome_m1_reg;
    logic           vm1_reg;

    logic [P1W-1:0] p1b_reg;
    logic [UDW+30:0] pl_reg;
    logic [UDW+30:0] ph_reg;
    logic           pos_m2_reg;
    logic           dome_m2_reg;
    logic           vm2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vt_reg  <= 1'b0;
            va_reg  <= 1'b0;
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
            done    <= 1'b0;
        end
        else
        begin
            vt_reg  <= vs;
            va_reg  <= vt_reg;
            vm1_reg <= va_reg;
            vm2_reg <= vm1_reg;
            done    <= vm2_reg;
        end
    end

    // final saturation
    logic [FULW-1:0] full;
    logic [FULW-1:0] sh;
    logic [P1W-1:0]  mag;

    assign full = FULW'({ph_reg, {UDW{1'b0}}}) + FULW'(pl_reg);
    assign sh   = full >> (2 * FRAC_BITS + 1);
    assign mag  = p1b_reg >> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        dome_t_reg <= side_s.dome;

        ud_reg     <= d_reg[ishs_pkg::D_W-1] ? UDW'(-d_reg) : UDW'(d_reg);
        pos_a_reg  <= !d_reg[ishs_pkg::D_W-1] && (d_reg != '0);
        dome_a_reg <= dome_t_reg;

        p1_reg      <= spring_reg * ud_reg;
        sq_reg      <= ud_reg * ud_reg;
        pos_m1_reg  <= pos_a_reg;
        dome_m1_reg <= dome_a_reg;

        p1b_reg     <= p1_reg;
        pl_reg      <= sq_reg[UDW-1:0] * spring_reg;
        ph_reg      <= sq_reg[SQW-1:UDW] * spring_reg;
        pos_m2_reg  <= pos_m1_reg;
        dome_m2_reg <= dome_m1_reg;

        result.in_dome <= dome_m2_reg;
        if (sh > FULW'({48{1'b1}}))
        begin
            result.score <= {48{1'b1}};
        end
        else
        begin
            result.score <= sh[47:0];
        end
        if (pos_m2_reg)
        begin
            if (mag > P1W'(48'h8000_0000_0000))
            begin
                result.deriv_z <= 48'sh8000_0000_0000;
            end
            else
            begin
                result.deriv_z <= 48'(-mag);
            end
        end
        else
        begin
            if (mag > P1W'(48'h7FFF_FFFF_FFFF))
            begin
                result.deriv_z <= 48'sh7FFF_FFFF_FFFF;
            end
            else
            begin
                result.deriv_z <= mag[47:0];
            end
        end
    end

`ifndef SYNTH
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 39))
        else $error("result word without matching command");
    a_plane_flag: assert property (@(posedge clk) disable iff (!rst_n)
        vt_reg |=> (dome_a_reg == $past(dome_t_reg)))
        else $error("dome flag lost between stages");
    a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (va_reg && ud_reg == '0) |=> (p1_reg == '0 && sq_reg == '0))
        else $error("nonzero product for zero offset");
`endif

endmodule
